### hdl/maze_carver_top_defines.svh
// Assertion macros used by the maze carver top level.
`ifndef MAZE_CARVER_TOP_DEFINES_SVH
`define MAZE_CARVER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and quiet while rst_ni is low.
`define MZC_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and quiet while rst_ni is low.
`define MZC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mzc_pkg.sv
// Shared types, constants and helpers of the maze carver.
`timescale 1ns / 1ps
`default_nettype none
package mzc_pkg;

  localparam int MZC_MAX_COLS = 64;
  localparam int MZC_MAX_ROWS = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GRID_DIM_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd2;

  localparam logic [GRID_DIM_W-1:0] GRID_DIM_RESET = 7'd64;

  localparam logic [1:0] OP_GENERATE = 2'd0;
  localparam logic [1:0] OP_CARVE    = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_PY = 2'd1;
  localparam logic [1:0] DIR_MX = 2'd2;
  localparam logic [1:0] DIR_MY = 2'd3;

  localparam logic [2:0]  DIR_COUNT  = 3'd4;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] LFSR_RESET = 16'h0001;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
  } req_t;

  typedef struct packed {
    logic cell_wall;
    logic status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RWAIT,
    ST_FILL,
    ST_OPEN,
    ST_SCAN,
    ST_CSTART,
    ST_TRY,
    ST_RFAR,
    ST_CHK,
    ST_MOVE,
    ST_DONE
  } state_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic latch_req;
    logic clr_step;
    logic fill_init;
    logic fill_step;
    logic open_origin;
    logic scan_init;
    logic scan_row;
    logic scan_next;
    logic walk_start;
    logic walk_from_scan;
    logic rd_cell;
    logic rd_far;
    logic mid_capture;
    logic wr_mid;
    logic wr_far_move;
    logic try_fail;
    logic set_status;
    logic set_wall;
    logic load_out;
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [1:0] op;
    logic       cell_out;
    logic       grid_nonempty;
    logic       fill_last;
    logic       scan_x_end;
    logic       scan_y_end;
    logic       tries_zero;
    logic       step_ok;
    logic       both_walls;
    logic       clr_last;
  } stat_t;

  // Galois LFSR, one right shift.
  function automatic logic [15:0] lfsr_next(input logic [15:0] cur);
    logic [15:0] nxt;
    nxt = {1'b0, cur[15:1]};
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

### hdl/mzc_if.sv
// Request and response channel interfaces of the maze carver.
`timescale 1ns / 1ps
`default_nettype none
interface mzc_req_if;
  logic          valid;
  logic          ready;
  mzc_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mzc_rsp_if;
  logic          valid;
  logic          ready;
  mzc_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/mzc_ctrl.sv
// Sequencing state machine of the maze carver.
`timescale 1ns / 1ps
`default_nettype none
module mzc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output      logic           req_ready_o,
  input  wire logic           rsp_ready_i,
  output      logic           rsp_valid_o,
  input  wire mzc_pkg::stat_t stat_i,
  output      mzc_pkg::cmd_t  cmd_o
);

  mzc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            gen_mode;
  logic            out_free;

  assign gen_mode = (stat_i.op == mzc_pkg::OP_GENERATE);
  assign out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mzc_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mzc_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) state_d = mzc_pkg::ST_IDLE;
      end
      mzc_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = mzc_pkg::ST_DECODE;
      end
      mzc_pkg::ST_DECODE: begin
        unique case (stat_i.op)
          mzc_pkg::OP_GENERATE: begin
            state_d = stat_i.grid_nonempty ? mzc_pkg::ST_FILL : mzc_pkg::ST_OPEN;
          end
          mzc_pkg::OP_CARVE: begin
            state_d = stat_i.cell_out ? mzc_pkg::ST_DONE : mzc_pkg::ST_CSTART;
          end
          mzc_pkg::OP_READ: begin
            state_d = stat_i.cell_out ? mzc_pkg::ST_DONE : mzc_pkg::ST_RWAIT;
          end
          default: begin
            state_d = mzc_pkg::ST_DONE;
          end
        endcase
      end
      mzc_pkg::ST_RWAIT: state_d = mzc_pkg::ST_DONE;
      mzc_pkg::ST_FILL: begin
        if (stat_i.fill_last) state_d = mzc_pkg::ST_OPEN;
      end
      mzc_pkg::ST_OPEN: state_d = mzc_pkg::ST_SCAN;
      mzc_pkg::ST_SCAN: begin
        priority if (stat_i.scan_y_end) begin
          state_d = mzc_pkg::ST_DONE;
        end else if (!stat_i.scan_x_end) begin
          state_d = mzc_pkg::ST_CSTART;
        end
      end
      mzc_pkg::ST_CSTART: state_d = mzc_pkg::ST_TRY;
      mzc_pkg::ST_TRY: begin
        priority if (stat_i.tries_zero) begin
          state_d = gen_mode ? mzc_pkg::ST_SCAN : mzc_pkg::ST_DONE;
        end else if (stat_i.step_ok) begin
          state_d = mzc_pkg::ST_RFAR;
        end
      end
      mzc_pkg::ST_RFAR: state_d = mzc_pkg::ST_CHK;
      mzc_pkg::ST_CHK: begin
        state_d = stat_i.both_walls ? mzc_pkg::ST_MOVE : mzc_pkg::ST_TRY;
      end
      mzc_pkg::ST_MOVE: state_d = mzc_pkg::ST_TRY;
      mzc_pkg::ST_DONE: begin
        if (out_free) state_d = mzc_pkg::ST_IDLE;
      end
      default: state_d = mzc_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      mzc_pkg::ST_CLEAR: cmd_o.clr_step = 1'b1;
      mzc_pkg::ST_IDLE: begin
        req_ready_o     = 1'b1;
        cmd_o.latch_req = req_valid_i;
      end
      mzc_pkg::ST_DECODE: begin
        cmd_o.fill_init  = gen_mode;
        cmd_o.rd_cell    = 1'b1;
        cmd_o.set_status = stat_i.cell_out &&
                           (stat_i.op == mzc_pkg::OP_CARVE || stat_i.op == mzc_pkg::OP_READ);
      end
      mzc_pkg::ST_RWAIT: cmd_o.set_wall = 1'b1;
      mzc_pkg::ST_FILL:  cmd_o.fill_step = 1'b1;
      mzc_pkg::ST_OPEN: begin
        cmd_o.open_origin = 1'b1;
        cmd_o.scan_init   = 1'b1;
      end
      mzc_pkg::ST_SCAN: begin
        cmd_o.scan_row = !stat_i.scan_y_end && stat_i.scan_x_end;
      end
      mzc_pkg::ST_CSTART: begin
        cmd_o.walk_start     = 1'b1;
        cmd_o.walk_from_scan = gen_mode;
      end
      mzc_pkg::ST_TRY: begin
        cmd_o.scan_next = stat_i.tries_zero && gen_mode;
        cmd_o.try_fail  = !stat_i.tries_zero && !stat_i.step_ok;
      end
      mzc_pkg::ST_RFAR: begin
        cmd_o.rd_far      = 1'b1;
        cmd_o.mid_capture = 1'b1;
      end
      mzc_pkg::ST_CHK: begin
        cmd_o.wr_mid   = stat_i.both_walls;
        cmd_o.try_fail = !stat_i.both_walls;
      end
      mzc_pkg::ST_MOVE: cmd_o.wr_far_move = 1'b1;
      mzc_pkg::ST_DONE: cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule
`default_nettype wire

### hdl/mzc_datapath.sv
// Grid memory, walk registers, scan counters and LFSR of the maze carver.
`timescale 1ns / 1ps
`default_nettype none
module mzc_datapath #(
  parameter int MAX_COLS = mzc_pkg::MZC_MAX_COLS,
  parameter int MAX_ROWS = mzc_pkg::MZC_MAX_ROWS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mzc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mzc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire mzc_pkg::req_t                    req_payload_i,
  input  wire mzc_pkg::cmd_t                    cmd_i,
  output      mzc_pkg::stat_t                   stat_o,
  output      mzc_pkg::rsp_t                    rsp_payload_o
);

  localparam int CXW   = $clog2(MAX_COLS);
  localparam int CYW   = $clog2(MAX_ROWS);
  localparam int SXW   = CXW + 1;
  localparam int SYW   = CYW + 1;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMPXW = (SXW > 6) ? SXW : 6;
  localparam int CMPYW = (SYW > 6) ? SYW : 6;

  function automatic logic [AW-1:0] cell_addr(input logic [CXW-1:0] x,
                                               input logic [CYW-1:0] y);
    return AW'(y) * AW'(MAX_COLS) + AW'(x);
  endfunction

  // Configuration
  logic [mzc_pkg::GRID_DIM_W-1:0] grid_width_q, grid_height_q;
  logic [15:0]                    lfsr_q, lfsr_nx;

  // Request and walk state
  logic [1:0]     op_q;
  logic [5:0]     cell_x_q, cell_y_q;
  logic [CXW-1:0] walk_x_q;
  logic [CYW-1:0] walk_y_q;
  logic [1:0]     dir_q;
  logic [2:0]     tries_q;
  logic [SXW-1:0] scan_x_q;
  logic [SYW-1:0] scan_y_q;
  logic [AW-1:0]  clr_q;
  logic           mid_q;
  logic           res_wall_q, res_status_q;
  logic           out_wall_q, out_status_q;

  // Grid memory
  logic           mem [DEPTH];
  logic           rdata_q;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic           wdata;

  logic [SXW-1:0] eff_w;
  logic [SYW-1:0] eff_h;
  logic           origin_ok, fill_last_col;
  logic           step_ok;
  logic [CXW-1:0] mid_x, far_x;
  logic [CYW-1:0] mid_y, far_y;
  logic [AW-1:0]  mid_addr, far_addr, cell_rd_addr, scan_addr, clr_last_addr;

  assign lfsr_nx = mzc_pkg::lfsr_next(lfsr_q);

  assign eff_w = (int'(grid_width_q) > MAX_COLS) ? SXW'(MAX_COLS) : SXW'(grid_width_q);
  assign eff_h = (int'(grid_height_q) > MAX_ROWS) ? SYW'(MAX_ROWS) : SYW'(grid_height_q);

  assign origin_ok     = (eff_w > SXW'(1)) && (eff_h > SYW'(1));
  assign fill_last_col = (scan_x_q == eff_w - SXW'(1));

  // Step geometry: the far cell must sit strictly inside the grid.
  always_comb begin
    step_ok = 1'b0;
    mid_x   = walk_x_q;
    far_x   = walk_x_q;
    mid_y   = walk_y_q;
    far_y   = walk_y_q;
    unique case (dir_q)
      mzc_pkg::DIR_PX: begin
        step_ok = (SXW'(walk_x_q) + SXW'(2) < eff_w) && (walk_y_q != '0);
        mid_x   = walk_x_q + CXW'(1);
        far_x   = walk_x_q + CXW'(2);
      end
      mzc_pkg::DIR_PY: begin
        step_ok = (SYW'(walk_y_q) + SYW'(2) < eff_h) && (walk_x_q != '0);
        mid_y   = walk_y_q + CYW'(1);
        far_y   = walk_y_q + CYW'(2);
      end
      mzc_pkg::DIR_MX: begin
        step_ok = (walk_x_q >= CXW'(3)) && (walk_y_q != '0);
        mid_x   = walk_x_q - CXW'(1);
        far_x   = walk_x_q - CXW'(2);
      end
      mzc_pkg::DIR_MY: begin
        step_ok = (walk_y_q >= CYW'(3)) && (walk_x_q != '0);
        mid_y   = walk_y_q - CYW'(1);
        far_y   = walk_y_q - CYW'(2);
      end
      default: step_ok = 1'b0;
    endcase
  end

  assign mid_addr      = cell_addr(mid_x, walk_y_q == mid_y ? walk_y_q : mid_y);
  assign far_addr      = cell_addr(far_x, far_y);
  assign cell_rd_addr  = cell_addr(CXW'(cell_x_q), CYW'(cell_y_q));
  assign scan_addr     = cell_addr(CXW'(scan_x_q), CYW'(scan_y_q));
  assign clr_last_addr = AW'(DEPTH - 1);

  always_comb begin
    we    = 1'b0;
    waddr = mid_addr;
    wdata = 1'b0;
    priority if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = 1'b1;
    end else if (cmd_i.fill_step) begin
      we    = 1'b1;
      waddr = scan_addr;
      wdata = 1'b1;
    end else if (cmd_i.open_origin) begin
      we    = origin_ok;
      waddr = cell_addr(CXW'(1), CYW'(1));
    end else if (cmd_i.wr_mid) begin
      we    = 1'b1;
      waddr = mid_addr;
    end else if (cmd_i.wr_far_move) begin
      we    = 1'b1;
      waddr = far_addr;
    end
  end

  always_comb begin
    priority if (cmd_i.rd_cell) begin
      raddr = cell_rd_addr;
    end else if (cmd_i.rd_far) begin
      raddr = far_addr;
    end else begin
      raddr = mid_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Configuration registers and LFSR
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= mzc_pkg::GRID_DIM_RESET;
      grid_height_q <= mzc_pkg::GRID_DIM_RESET;
      lfsr_q        <= mzc_pkg::LFSR_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mzc_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[mzc_pkg::GRID_DIM_W-1:0];
          mzc_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[mzc_pkg::GRID_DIM_W-1:0];
          mzc_pkg::CFG_RANDOM_SEED: begin
            lfsr_q <= (cfg_wdata_i == '0) ? mzc_pkg::LFSR_RESET : cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end else if (cmd_i.walk_start || cmd_i.wr_far_move) begin
        lfsr_q <= lfsr_nx;
      end
    end
  end

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      walk_x_q <= '0;
      walk_y_q <= '0;
      dir_q    <= '0;
      tries_q  <= '0;
      scan_x_q <= '0;
      scan_y_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end

      priority if (cmd_i.fill_init) begin
        scan_x_q <= '0;
        scan_y_q <= '0;
      end else if (cmd_i.fill_step) begin
        if (fill_last_col) begin
          scan_x_q <= '0;
          scan_y_q <= scan_y_q + SYW'(1);
        end else begin
          scan_x_q <= scan_x_q + SXW'(1);
        end
      end else if (cmd_i.scan_init) begin
        scan_x_q <= SXW'(1);
        scan_y_q <= SYW'(1);
      end else if (cmd_i.scan_row) begin
        scan_x_q <= SXW'(1);
        scan_y_q <= scan_y_q + SYW'(2);
      end else if (cmd_i.scan_next) begin
        scan_x_q <= scan_x_q + SXW'(2);
      end

      priority if (cmd_i.walk_start) begin
        walk_x_q <= cmd_i.walk_from_scan ? CXW'(scan_x_q) : CXW'(cell_x_q);
        walk_y_q <= cmd_i.walk_from_scan ? CYW'(scan_y_q) : CYW'(cell_y_q);
        dir_q    <= lfsr_nx[1:0];
        tries_q  <= mzc_pkg::DIR_COUNT;
      end else if (cmd_i.wr_far_move) begin
        walk_x_q <= far_x;
        walk_y_q <= far_y;
        dir_q    <= lfsr_nx[1:0];
        tries_q  <= mzc_pkg::DIR_COUNT;
      end else if (cmd_i.try_fail) begin
        dir_q   <= dir_q + 2'd1;
        tries_q <= tries_q - 3'd1;
      end
    end
  end

  // Request fields and results
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      op_q         <= req_payload_i.opcode;
      cell_x_q     <= req_payload_i.cell_x;
      cell_y_q     <= req_payload_i.cell_y;
      res_wall_q   <= 1'b0;
      res_status_q <= 1'b0;
    end else begin
      if (cmd_i.set_status) res_status_q <= 1'b1;
      if (cmd_i.set_wall)   res_wall_q   <= rdata_q;
    end
    if (cmd_i.mid_capture) mid_q <= rdata_q;
    if (cmd_i.load_out) begin
      out_wall_q   <= res_wall_q;
      out_status_q <= res_status_q;
    end
  end

  always_comb begin
    stat_o.op            = op_q;
    stat_o.cell_out      = (CMPXW'(cell_x_q) >= CMPXW'(eff_w)) ||
                           (CMPYW'(cell_y_q) >= CMPYW'(eff_h));
    stat_o.grid_nonempty = (eff_w != '0) && (eff_h != '0);
    stat_o.fill_last     = fill_last_col && (scan_y_q == eff_h - SYW'(1));
    stat_o.scan_x_end    = (scan_x_q >= eff_w);
    stat_o.scan_y_end    = (scan_y_q >= eff_h);
    stat_o.tries_zero    = (tries_q == '0);
    stat_o.step_ok       = step_ok;
    stat_o.both_walls    = mid_q && rdata_q;
    stat_o.clr_last      = (clr_q == clr_last_addr);
  end

  assign rsp_payload_o.cell_wall = out_wall_q;
  assign rsp_payload_o.status    = out_status_q;

endmodule
`default_nettype wire

### hdl/maze_carver_top.sv
// Top level of the maze carver: wall grid with randomized depth-walk carving.
//
// Usage:
//   req channel carries opcode, cell_x, cell_y; rsp channel returns one
//   response (cell_wall, status) for every accepted request. Opcode 0
//   generates a maze over the configured grid, 1 carves one walk from a
//   cell, 2 reads one cell, 3 does nothing.
//   Config port: cfg_we_i with cfg_idx_i 0 width, 1 height, 2 LFSR seed.
//   Write it only while no request is in flight.
// Flow: one request at a time; a new request is taken only once the current
// one is done. Steps per request:
//   read          : one registered read of the addressed cell
//   carve walk    : a bound check per try, a probe of the middle and far cells,
//                   and a step when both are walls
//   generate      : the w*h grid is filled with walls, then each cell with odd
//                   x and odd y gets its walk
// Reset: the grid is swept to all walls, one cell per cycle; req.ready
//   stays low until the sweep ends.
// Backpressure: a response waiting on rsp.ready does not block the next
//   request; its result holds internally until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "maze_carver_top_defines.svh"
module maze_carver_top #(
  parameter int MAX_COLS = mzc_pkg::MZC_MAX_COLS,
  parameter int MAX_ROWS = mzc_pkg::MZC_MAX_ROWS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mzc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mzc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mzc_req_if.sink                             req,
  mzc_rsp_if.source                           rsp
);

  mzc_pkg::cmd_t  cmd;
  mzc_pkg::stat_t stat;
  mzc_pkg::rsp_t  rsp_payload;
  logic           req_ready;
  logic           rsp_valid;

  // Sequencer: one request in flight, generate/carve/read flows.
  mzc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req_ready),
    .rsp_ready_i (rsp.ready),
    .rsp_valid_o (rsp_valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Grid memory, walk/scan registers, LFSR and config registers.
  mzc_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_payload_i (req.payload),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rsp_payload_o (rsp_payload)
  );

  assign req.ready   = req_ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_payload;

  // A request is worked on alone: accepting one closes the request side.
  `MZC_ASSERT_NEXT(a_single_request, req.valid && req.ready, !req.ready, "request accepted while busy")

  // A rejected coordinate never reports a wall.
  `MZC_ASSERT_HOLDS(a_reject_no_wall, rsp.valid && rsp.payload.status, !rsp.payload.cell_wall, "wall set on rejected request")

endmodule
`default_nettype wire

### bench/maze_carver_top_tb.sv
// Self-checking testbench for maze_carver_top: random requests against a grid predictor.
`timescale 1ns / 1ps
module maze_carver_top_tb;
  import mzc_pkg::*;

  // Opcode 3 has no name in the package; the block answers it and does nothing.
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int GRID_CELLS    = MZC_MAX_COLS * MZC_MAX_ROWS;
  localparam int IDLE_PCT      = 22;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  // Slowest sane run: the clearing sweep, a handful of 64x64 generates,
  // ~100 short requests, random stalls on both sides.
  // That stays well under this limit, so this bound only catches a hang.
  localparam int CYCLE_LIMIT   = 1_500_000;

  // Predicts every response from its own copy of the wall grid, the grid size
  // and the direction LFSR, and checks responses in order.
  class maze_scoreboard;
    bit                    wall_bits [GRID_CELLS];
    logic [GRID_DIM_W-1:0] cols_reg;
    logic [GRID_DIM_W-1:0] rows_reg;
    logic [15:0]           lfsr;
    rsp_t                  expected_q [$];
    int                    fail_count;

    function new();
      foreach (wall_bits[i]) wall_bits[i] = 1'b1;
      cols_reg   = GRID_DIM_RESET;
      rows_reg   = GRID_DIM_RESET;
      lfsr       = LFSR_RESET;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:  cols_reg = data[GRID_DIM_W-1:0];
        CFG_GRID_HEIGHT: rows_reg = data[GRID_DIM_W-1:0];
        // A zero seed would lock the LFSR, so it loads the reset value.
        CFG_RANDOM_SEED: lfsr = (data == '0) ? LFSR_RESET : data;
        default: ;
      endcase
    endfunction

    function logic [1:0] next_dir();
      logic shifted_out;
      shifted_out = lfsr[0];
      lfsr = lfsr >> 1;
      if (shifted_out) lfsr = lfsr ^ LFSR_TAPS;
      return lfsr[1:0];
    endfunction

    // Random depth walk: a step needs the far cell strictly inside the grid
    // and both the middle and far cells still walls. Four misses end it.
    // The start cell is never opened here.
    function void carve_walk(int sx, int sy, int w, int h);
      int px, py, dx, dy, mx, my, fx, fy, tries;
      logic [1:0] dir;
      px    = sx;
      py    = sy;
      dir   = next_dir();
      tries = DIR_COUNT;
      while (tries > 0) begin
        dx = 0;
        dy = 0;
        case (dir)
          DIR_PX: dx = 1;
          DIR_PY: dy = 1;
          DIR_MX: dx = -1;
          default: dy = -1;
        endcase
        mx = px + dx;
        my = py + dy;
        fx = px + 2 * dx;
        fy = py + 2 * dy;
        if (fx > 0 && fx < w && fy > 0 && fy < h &&
            wall_bits[my * MZC_MAX_COLS + mx] && wall_bits[fy * MZC_MAX_COLS + fx]) begin
          wall_bits[my * MZC_MAX_COLS + mx] = 1'b0;
          wall_bits[fy * MZC_MAX_COLS + fx] = 1'b0;
          px    = fx;
          py    = fy;
          dir   = next_dir();
          tries = DIR_COUNT;
        end else begin
          dir   = dir + 2'd1;
          tries = tries - 1;
        end
      end
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      int   w, h, x, y;
      want = '0;
      w = (cols_reg > MZC_MAX_COLS) ? MZC_MAX_COLS : int'(cols_reg);
      h = (rows_reg > MZC_MAX_ROWS) ? MZC_MAX_ROWS : int'(rows_reg);
      case (r.opcode)
        OP_GENERATE: begin
          // Cells outside the grid in use keep their value.
          for (y = 0; y < h; y++)
            for (x = 0; x < w; x++) wall_bits[y * MZC_MAX_COLS + x] = 1'b1;
          if (w > 1 && h > 1) wall_bits[MZC_MAX_COLS + 1] = 1'b0;
          for (y = 1; y < h; y += 2)
            for (x = 1; x < w; x += 2) carve_walk(x, y, w, h);
        end
        OP_CARVE, OP_READ: begin
          if (int'(r.cell_x) >= w || int'(r.cell_y) >= h) begin
            want.status = 1'b1;
          end else if (r.opcode == OP_CARVE) begin
            carve_walk(r.cell_x, r.cell_y, w, h);
          end else begin
            want.cell_wall = wall_bits[int'(r.cell_y) * MZC_MAX_COLS + int'(r.cell_x)];
          end
        end
        default: ;
      endcase
      expected_q.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("response with none pending: wall %0b status %0b", got.cell_wall, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.cell_wall !== want.cell_wall || got.status !== want.status) begin
        fail_count++;
        if (fail_count <= 10)
          $display("response mismatch: wall exp %0b got %0b, status exp %0b got %0b",
                   want.cell_wall, got.cell_wall, want.status, got.status);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mzc_req_if req_bus ();
  mzc_rsp_if rsp_bus ();

  maze_carver_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  maze_scoreboard board = new();

  // quiet: no random gaps on either side. hold_req: ask the response side
  // for one long hold-off, counted down in its own process.
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("maze_carver_top_tb NOT OK");
      $finish;
    end
  end

  // Handshakes are sampled at the edge, before any update of that edge lands.
  // The request is noted first so a prediction never trails its response.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) board.note_request(req_bus.payload);
      if (rsp_bus.valid && rsp_bus.ready) board.check_response(rsp_bus.payload);
    end
  end

  // Response side: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int hold_left;
    hold_left     = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (quiet) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one request, maybe after a short gap, and returns right after the
  // edge that took it. valid stays high so the next request can follow at once.
  task automatic send_request(input logic [1:0] op, input int x, input int y);
    req_t item;
    item.opcode = op;
    item.cell_x = x[5:0];
    item.cell_y = y[5:0];
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.payload <= item;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
  endtask

  // Stop offering and wait until every response is back, then let the block
  // settle. The first edge lets the monitor note the last accepted request.
  task automatic settle();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Back-to-back writes of all three registers; only called while idle.
  task automatic program_grid(input int cols, input int rows, input logic [15:0] seed);
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    int i;
    regs[0] = CFG_GRID_WIDTH;
    regs[1] = CFG_GRID_HEIGHT;
    regs[2] = CFG_RANDOM_SEED;
    vals[0] = CFG_DATA_W'(cols);
    vals[1] = CFG_DATA_W'(rows);
    vals[2] = seed;
    for (i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= regs[i];
      cfg_wdata_i <= vals[i];
      board.write_reg(regs[i], vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Grid sizes: mostly small so generates stay cheap, sometimes degenerate
  // or oversized (above the max acts as the max).
  function automatic int pick_dim();
    case ($urandom_range(9))
      0: return $urandom_range(2);
      1: return $urandom_range(127, 17);
      default: return $urandom_range(16, 3);
    endcase
  endfunction

  // Mostly inside the grid in use, sometimes anywhere in the field range.
  function automatic int pick_coord(int span);
    if (span > 0 && $urandom_range(99) < 80) return $urandom_range(span - 1);
    return $urandom_range(63);
  endfunction

  initial begin
    int served, phase, n, k, x, y, span_x, span_y, pick;
    logic [1:0] op;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, 64x64, seed 1. The first request waits out the clearing sweep.
    send_request(OP_READ, 0, 0);
    send_request(OP_READ, 63, 63);
    send_request(OP_CARVE, 1, 1);       // long walk through an all-wall grid
    send_request(OP_READ, 1, 1);        // walk start stays a wall
    send_request(OP_READ, 2, 1);
    send_request(OP_NONE, 63, 63);
    send_request(OP_GENERATE, 0, 0);
    send_request(OP_READ, 1, 1);
    send_request(OP_READ, 0, 0);
    // Fill the block: responses held off while reads keep coming.
    quiet    = 1'b1;
    hold_req = 1'b1;
    for (k = 0; k < 6; k++) send_request(OP_READ, $urandom_range(63), $urandom_range(63));
    settle();
    quiet = 1'b0;

    // Oversized grid with zero seed.
    program_grid(127, 127, 16'h0000);
    send_request(OP_GENERATE, 63, 63);
    send_request(OP_READ, 63, 63);
    send_request(OP_CARVE, 63, 63);
    send_request(OP_READ, 62, 63);
    settle();

    // Smallest legal grid, all-ones seed; out-of-grid carve and read.
    program_grid(3, 3, 16'hFFFF);
    send_request(OP_GENERATE, 0, 0);
    send_request(OP_READ, 1, 1);
    send_request(OP_READ, 3, 0);
    send_request(OP_CARVE, 0, 3);
    send_request(OP_CARVE, 1, 1);
    settle();

    // Tiny grid: generate must not open (1,1).
    program_grid(1, 2, 16'h8000);
    send_request(OP_GENERATE, 0, 0);
    send_request(OP_READ, 0, 1);
    send_request(OP_READ, 1, 0);
    settle();

    // Empty grid: everything is out of range.
    program_grid(0, 0, 16'h1234);
    send_request(OP_READ, 0, 0);
    send_request(OP_GENERATE, 0, 0);
    settle();

    // Random phases: new settings, usually a fresh maze, then carves and reads,
    // with carves biased to odd cells so walks start from maze positions.
    served = 0;
    phase  = 0;
    while (served < 70) begin
      x      = pick_dim();
      y      = pick_dim();
      span_x = (x > MZC_MAX_COLS) ? MZC_MAX_COLS : x;
      span_y = (y > MZC_MAX_ROWS) ? MZC_MAX_ROWS : y;
      program_grid(x, y, ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom_range(65535)));
      quiet = (phase % 4 == 2);
      if ($urandom_range(99) < 85) begin
        send_request(OP_GENERATE, $urandom_range(63), $urandom_range(63));
        served++;
      end
      n = $urandom_range(14, 6);
      for (k = 0; k < n; k++) begin
        pick = $urandom_range(99);
        op = (pick < 40) ? OP_CARVE : (pick < 88) ? OP_READ :
             (pick < 93) ? OP_NONE : OP_GENERATE;
        x = pick_coord(span_x);
        y = pick_coord(span_y);
        if (op == OP_CARVE && (x | 1) < span_x) x = x | 1;
        if (op == OP_CARVE && (y | 1) < span_y) y = y | 1;
        send_request(op, x, y);
        if (op != OP_NONE) served++;
      end
      settle();
      quiet = 1'b0;
      phase++;
    end

    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("maze_carver_top_tb OK");
    end else begin
      $display("maze_carver_top_tb NOT OK");
    end
    $finish;
  end

endmodule
